@@ rtl/core/four_level_page_table_fill_macros.svh @@
// Assertion macros shared by the checker of the page table fill block.
// Depends on nothing; the including module provides clk and rst.
`ifndef FOUR_LEVEL_PAGE_TABLE_FILL_MACROS_SVH
`define FOUR_LEVEL_PAGE_TABLE_FILL_MACROS_SVH

// Condition that holds at every clock edge outside reset.
`define PGFILL_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Implication with the consequent checked in the cycle after the antecedent.
`define PGFILL_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/core/pgfill_pkg.sv @@
// Package of the page table fill block: sizes, level codes, entry and memory request types.
// Used by every module of the block; depends on nothing.
package pgfill_pkg;

  localparam int PAGE_BITS   = 6;
  localparam int TABLE_PAGES = 1 << PAGE_BITS;
  localparam int IDX_BITS    = 9;
  localparam int ADDR_BITS   = PAGE_BITS + IDX_BITS;
  localparam int MEM_DEPTH   = TABLE_PAGES << IDX_BITS;
  localparam int FRAME_W     = 40;
  localparam int VPAGE_W     = 36;
  localparam int COUNT_W     = 16;
  localparam int NEXT_W      = PAGE_BITS + 1;
  localparam int TIU_W       = 7;
  localparam int IN_W        = 96;
  localparam int OUT_W       = 24;

  localparam logic [1:0] LVL_PML4 = 2'd0;
  localparam logic [1:0] LVL_PDPT = 2'd1;
  localparam logic [1:0] LVL_PD   = 2'd2;
  localparam logic [1:0] LVL_PT   = 2'd3;

  typedef logic [PAGE_BITS-1:0] page_t;
  typedef logic [ADDR_BITS-1:0] addr_t;

  // The tag bit marks an entry as written after its page was last handed out.
  typedef struct packed {
    logic               tag;
    logic               valid;
    logic [FRAME_W-1:0] frame;
  } entry_t;

  typedef struct packed {
    logic   we;
    addr_t  waddr;
    entry_t wdata;
    logic   re;
    addr_t  raddr;
  } mem_req_t;

  function automatic logic [IDX_BITS-1:0] level_index(input logic [VPAGE_W-1:0] vpage,
                                                      input logic [1:0] level);
    logic [IDX_BITS-1:0] idx;
    case (level)
      LVL_PML4: idx = vpage[35:27];
      LVL_PDPT: idx = vpage[26:18];
      LVL_PD:   idx = vpage[17:9];
      default:  idx = vpage[8:0];
    endcase
    return idx;
  endfunction

endpackage

@@ rtl/core/pgfill_mem.sv @@
// Table store: one synchronous memory of all pool pages, one write and one read port.
// Depends on pgfill_pkg for the entry and request types.
module pgfill_mem
  import pgfill_pkg::*;
(
  input  logic     clk,
  input  mem_req_t req,
  output entry_t   rdata
);

  entry_t store [MEM_DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      store[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rdata <= store[req.raddr];
    end
  end

endmodule

@@ rtl/core/pgfill_walk.sv @@
// Walk sequencer: clears the store after reset, walks the four levels for each page,
// allocates tables from the pool and writes leaf entries. Depends on pgfill_pkg.
module pgfill_walk
  import pgfill_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic [FRAME_W-1:0]  base_frame,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [VPAGE_W-1:0]  in_vpage,
  input  logic [FRAME_W-1:0]  in_frame,
  input  logic [COUNT_W-1:0]  in_count,
  output logic                res_valid,
  input  logic                res_ready,
  output logic                res_status,
  output logic [COUNT_W-1:0]  res_done,
  output logic [TIU_W-1:0]    res_tables,
  output mem_req_t            req,
  input  entry_t              rdata
);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_READ  = 6'b000100,
    S_EVAL  = 6'b001000,
    S_LEAF  = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t               state;
  addr_t                clr_addr;
  logic [VPAGE_W-1:0]   vpage;
  logic [FRAME_W-1:0]   frame;
  logic [COUNT_W-1:0]   count;
  logic [COUNT_W-1:0]   done_cnt;
  logic [1:0]           level;
  page_t                tbl;
  logic [NEXT_W-1:0]    next_free;
  logic                 status;
  logic [TABLE_PAGES-1:0] alloc_flag;

  addr_t                cur_addr;
  logic                 hit;
  logic [FRAME_W-1:0]   child_rel;
  page_t                child;
  logic                 pool_empty;
  page_t                new_page;
  logic                 slot_tag;
  logic [FRAME_W-1:0]   new_frame;
  logic [COUNT_W-1:0]   done_next;

  assign cur_addr   = {tbl, level_index(vpage, level)};
  assign hit        = rdata.valid && (rdata.tag == alloc_flag[tbl]);
  assign child_rel  = rdata.frame - base_frame;
  assign child      = child_rel[PAGE_BITS-1:0];
  assign pool_empty = (next_free == NEXT_W'(TABLE_PAGES));
  assign new_page   = next_free[PAGE_BITS-1:0];
  assign slot_tag   = (new_page == tbl) ? 1'b1 : alloc_flag[tbl];
  assign new_frame  = base_frame + FRAME_W'(new_page);
  assign done_next  = done_cnt + COUNT_W'(1);

  assign in_ready   = (state == S_IDLE);
  assign res_valid  = (state == S_DONE);
  assign res_status = status;
  assign res_done   = done_cnt;
  assign res_tables = TIU_W'(next_free);

  always_comb begin
    req = '0;
    unique case (state)
      S_CLEAR: begin
        req.we    = 1'b1;
        req.waddr = clr_addr;
      end
      S_READ: begin
        req.re    = 1'b1;
        req.raddr = cur_addr;
      end
      S_EVAL: begin
        req.we          = !hit && !pool_empty;
        req.waddr       = cur_addr;
        req.wdata.tag   = slot_tag;
        req.wdata.valid = 1'b1;
        req.wdata.frame = new_frame;
      end
      S_LEAF: begin
        req.we          = 1'b1;
        req.waddr       = cur_addr;
        req.wdata.tag   = alloc_flag[tbl];
        req.wdata.valid = 1'b1;
        req.wdata.frame = frame;
      end
      default: begin
        req = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      next_free  <= NEXT_W'(1);
      alloc_flag <= '0;
      status     <= 1'b0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_BITS'(1);
          if (&clr_addr) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            vpage    <= in_vpage;
            frame    <= in_frame;
            count    <= in_count;
            done_cnt <= '0;
            status   <= 1'b0;
            level    <= LVL_PML4;
            tbl      <= '0;
            state    <= (in_count == '0) ? S_DONE : S_READ;
          end
        end
        S_READ: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (hit) begin
            tbl   <= child;
            level <= level + 2'd1;
            state <= (level == LVL_PD) ? S_LEAF : S_READ;
          end else if (pool_empty) begin
            status <= 1'b1;
            state  <= S_DONE;
          end else begin
            alloc_flag[new_page] <= 1'b1;
            next_free            <= next_free + NEXT_W'(1);
            tbl                  <= new_page;
            level                <= level + 2'd1;
            state                <= (level == LVL_PD) ? S_LEAF : S_READ;
          end
        end
        S_LEAF: begin
          vpage    <= vpage + VPAGE_W'(1);
          frame    <= frame + FRAME_W'(1);
          done_cnt <= done_next;
          level    <= LVL_PML4;
          tbl      <= '0;
          state    <= (done_next == count) ? S_DONE : S_READ;
        end
        S_DONE: begin
          if (res_ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/core/four_level_page_table_fill.sv @@
// Top level of the four-level page table fill block: configuration register, output register,
// walk sequencer and table store. Depends on pgfill_pkg, pgfill_walk and pgfill_mem.
//
//   Channel   Direction  Handshake            Contents
//   s_        in         s_tvalid/s_tready    mapping request
//   m_        out        m_tvalid/m_tready    completion status
//   cfg_      in         cfg_wen              pool base frame
//
// After reset the store is cleared one entry a cycle, all 32768 entries, while s_tready is low.
// For each mapped page a request reads and then evaluates each of the three upper levels,
// allocating a table on a miss, then writes the leaf entry, all through the single table store.
// A pending result sits in the output register while the next request is already taken.
module four_level_page_table_fill
  import pgfill_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [IN_W-1:0]    s_tdata,   // virt_page, phys_frame, page_count
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [OUT_W-1:0]   m_tdata,   // status, pages_done, tables_in_use
  input  logic               cfg_wen,
  input  logic [FRAME_W-1:0] cfg_wdata
);

  logic [FRAME_W-1:0] pool_base_frame;
  logic               res_valid;
  logic               res_ready;
  logic               res_status;
  logic [COUNT_W-1:0] res_done;
  logic [TIU_W-1:0]   res_tables;
  mem_req_t           req;
  entry_t             rdata;

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base_frame <= '0;
      m_tvalid        <= 1'b0;
    end else begin
      if (cfg_wen) begin
        pool_base_frame <= cfg_wdata;
      end
      if (res_valid && res_ready) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {res_tables, res_done, res_status};
    end
  end

  pgfill_walk u_walk (
    .clk        (clk),
    .rst        (rst),
    .base_frame (pool_base_frame),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_vpage   (s_tdata[35:0]),
    .in_frame   (s_tdata[75:36]),
    .in_count   (s_tdata[91:76]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_status (res_status),
    .res_done   (res_done),
    .res_tables (res_tables),
    .req        (req),
    .rdata      (rdata)
  );

  pgfill_mem u_mem (
    .clk   (clk),
    .req   (req),
    .rdata (rdata)
  );

endmodule

@@ rtl/core/pgfill_chk.sv @@
// Port checker of the page table fill block, attached to the top level by a bind.
// Depends on pgfill_pkg and four_level_page_table_fill_macros.svh.
`include "four_level_page_table_fill_macros.svh"

module pgfill_chk
  import pgfill_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  `PGFILL_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result item dropped or changed while stalled")
  `PGFILL_ALWAYS(a_tables_range, !m_tvalid || (m_tdata[23:17] != '0 && m_tdata[23:17] <= TIU_W'(TABLE_PAGES)), "tables in use out of range")
  `PGFILL_ALWAYS(a_fail_full, !(m_tvalid && m_tdata[0]) || m_tdata[23:17] == TIU_W'(TABLE_PAGES), "pool failure reported with pool not full")
  `PGFILL_ALWAYS(a_clear_busy, !$fell(rst) || !s_tready, "request taken before the store was cleared")

endmodule

bind four_level_page_table_fill pgfill_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ tb/tb.sv @@
// Self-checking bench for four_level_page_table_fill: fills mapping requests, keeps a shadow
// copy of the table store and pool, and checks every completion status field by field.
// Depends on pgfill_pkg and the four_level_page_table_fill RTL.
module tb
  import pgfill_pkg::*;
;

  localparam int  CYCLE_LIMIT   = 3_000_000;
  localparam int  ENTRIES       = 1 << IDX_BITS;
  localparam int  IDLE_PERCENT  = 30;
  localparam int  HOLD_CYCLES   = 400;
  localparam logic ST_OK        = 1'b0;
  localparam logic ST_POOL_EMPTY = 1'b1;

  typedef struct packed {
    logic [3:0]         pad;
    logic [COUNT_W-1:0] count;
    logic [FRAME_W-1:0] frame;
    logic [VPAGE_W-1:0] vpage;
  } fill_req_t;

  typedef struct packed {
    logic [TIU_W-1:0]   tables;
    logic [COUNT_W-1:0] pages;
    logic               status;
  } fill_outcome_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  fill_req_t          s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [OUT_W-1:0]   m_tdata;
  logic               cfg_wen = 1'b0;
  logic [FRAME_W-1:0] cfg_wdata = '0;

  bit [63:0]          shadow_tables [MEM_DEPTH];
  int unsigned        shadow_next_free = 1;
  logic [FRAME_W-1:0] shadow_base = '0;

  fill_req_t          pending_reqs [$];
  fill_outcome_t      outcomes_due [$];
  logic [VPAGE_W-1:0] hot_pages [$];

  bit in_fire = 1'b0;
  int n_accepted = 0;
  int n_outcomes = 0;
  int errors = 0;
  int cycles = 0;
  int hold_left = 0;
  int next_hold_at = 150;
  bit calm;

  assign calm = (n_accepted >= 400) && (n_accepted < 500);

  four_level_page_table_fill u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_wen  (cfg_wen),
    .cfg_wdata(cfg_wdata)
  );

  always #10 clk = ~clk;

  function automatic logic [63:0] page_entry(input logic [FRAME_W-1:0] f);
    return {12'b0, f, 10'b0, 2'b11};
  endfunction

  task automatic follow_entry(input int unsigned tbl, input logic [IDX_BITS-1:0] idx,
                              output bit ok, output int unsigned child);
    int unsigned slot;
    logic [FRAME_W-1:0] rel;
    slot = (tbl % TABLE_PAGES) * ENTRIES + idx;
    ok = 1'b1;
    child = 0;
    if (shadow_tables[slot][0]) begin
      rel = shadow_tables[slot][51:12] - shadow_base;
      child = 32'(rel % TABLE_PAGES);
    end else if (shadow_next_free >= TABLE_PAGES) begin
      ok = 1'b0;
    end else begin
      child = shadow_next_free;
      shadow_next_free++;
      for (int k = 0; k < ENTRIES; k++) shadow_tables[child * ENTRIES + k] = '0;
      shadow_tables[slot] = page_entry(shadow_base + FRAME_W'(child));
    end
  endtask

  task automatic map_pages(input fill_req_t r, output fill_outcome_t o);
    logic [VPAGE_W-1:0] vp;
    logic [FRAME_W-1:0] fr;
    int unsigned done;
    int unsigned pdpt;
    int unsigned pd;
    int unsigned pt;
    bit ok;
    vp = r.vpage;
    fr = r.frame;
    done = 0;
    o.status = ST_OK;
    while (done < r.count) begin
      follow_entry(0, vp[35:27], ok, pdpt);
      if (ok) follow_entry(pdpt, vp[26:18], ok, pd);
      if (ok) follow_entry(pd, vp[17:9], ok, pt);
      if (!ok) begin
        o.status = ST_POOL_EMPTY;
        break;
      end
      shadow_tables[pt * ENTRIES + vp[8:0]] = page_entry(fr);
      vp = vp + 1'b1;
      fr = fr + 1'b1;
      done++;
    end
    o.pages = done[COUNT_W-1:0];
    o.tables = shadow_next_free[TIU_W-1:0];
  endtask

  task automatic add_req(input logic [VPAGE_W-1:0] v, input logic [FRAME_W-1:0] f,
                         input logic [COUNT_W-1:0] c);
    fill_req_t r;
    r.pad = '0;
    r.vpage = v;
    r.frame = f;
    r.count = c;
    pending_reqs.push_back(r);
    hot_pages.push_back(v);
  endtask

  task automatic write_base(input logic [FRAME_W-1:0] v);
    @(negedge clk);
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    shadow_base = v;
    @(negedge clk);
    cfg_wen <= 1'b0;
  endtask

  task automatic wait_idle();
    @(posedge clk);
    while (pending_reqs.size() > 0 || s_tvalid || outcomes_due.size() > 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Mostly requests near regions already built, with boundary crossings and fresh
  // regions that drain the pool, and a few longer runs.
  task automatic random_phase(input int n);
    fill_req_t r;
    logic [63:0] wide;
    logic [VPAGE_W-1:0] vp;
    int kind;
    for (int i = 0; i < n; i++) begin
      kind = $urandom_range(99);
      wide = {$urandom, $urandom};
      r.pad = '0;
      r.frame = wide[FRAME_W-1:0];
      if ($urandom_range(9) == 0) r.frame = '1 - FRAME_W'($urandom_range(3));
      wide = {$urandom, $urandom};
      vp = hot_pages[$urandom_range(hot_pages.size() - 1)] + VPAGE_W'($urandom_range(40));
      if (kind < 55) begin
        r.count = COUNT_W'($urandom_range(8));
      end else if (kind < 70) begin
        vp = wide[VPAGE_W-1:0];
        vp[8:0] = 9'h1FF - 9'($urandom_range(3));
        if ($urandom_range(1)) vp[17:9] = '1;
        r.count = COUNT_W'($urandom_range(8, 1));
        hot_pages.push_back(vp);
      end else if (kind < 80) begin
        vp = wide[VPAGE_W-1:0];
        r.count = COUNT_W'($urandom_range(4));
        hot_pages.push_back(vp);
      end else if (kind < 85) begin
        r.count = '0;
      end else if (kind < 95) begin
        r.count = COUNT_W'($urandom_range(64, 9));
      end else begin
        r.count = COUNT_W'($urandom_range(600, 65));
      end
      r.vpage = vp;
      pending_reqs.push_back(r);
    end
  endtask

  always @(posedge clk) begin
    fill_outcome_t o;
    in_fire = s_tvalid && s_tready;
    if (in_fire) begin
      map_pages(s_tdata, o);
      outcomes_due.push_back(o);
      n_accepted++;
    end
  end

  always @(negedge clk) begin
    if (!s_tvalid || in_fire) begin
      if (pending_reqs.size() > 0 && (calm || $urandom_range(99) >= IDLE_PERCENT)) begin
        s_tvalid <= 1'b1;
        s_tdata <= pending_reqs.pop_front();
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (n_accepted >= next_hold_at) begin
      hold_left <= HOLD_CYCLES;
      next_hold_at <= next_hold_at + 500;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(99) >= IDLE_PERCENT);
    end
  end

  always @(posedge clk) begin
    fill_outcome_t want;
    fill_outcome_t got;
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata;
      if (outcomes_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("tb: outcome %0d arrived with nothing due", n_outcomes);
      end else begin
        want = outcomes_due.pop_front();
        if (got.status !== want.status || got.pages !== want.pages ||
            got.tables !== want.tables) begin
          errors++;
          if (errors <= 10)
            $display("tb: outcome %0d expected status %0d pages %0d tables %0d, got %0d %0d %0d",
                     n_outcomes, want.status, want.pages, want.tables,
                     got.status, got.pages, got.tables);
        end
      end
      n_outcomes++;
    end
  end

  initial begin
    logic [63:0] wide;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    write_base('0);
    add_req('0, '0, '0);
    add_req('0, '0, 16'd1);
    add_req('1, '1, 16'd2);
    add_req('0, 40'h12_3456_789A, 16'd1);
    add_req(36'h1FE, FRAME_W'({$urandom, $urandom}), 16'd4);
    add_req(36'h3FFFE, FRAME_W'({$urandom, $urandom}), 16'd4);
    add_req(36'h7FF_FFFF, FRAME_W'({$urandom, $urandom}), 16'd2);
    add_req(36'hA_AAAA_AAAA, 40'h55_5555_5555, 16'd3);
    add_req(36'h5_5555_5555, 40'hAA_AAAA_AAAA, 16'd3);
    add_req(36'h8_0000_0000, 40'h80_0000_0000, 16'd1);
    add_req(36'h1, FRAME_W'({$urandom, $urandom}), '0);
    add_req('1, '0, 16'd1);
    add_req('0, FRAME_W'({$urandom, $urandom}), 16'd600);
    for (int i = 0; i < 3; i++) begin
      wide = {$urandom, $urandom};
      add_req(wide[VPAGE_W-1:0], FRAME_W'({$urandom, $urandom}),
              COUNT_W'($urandom_range(8, 1)));
    end
    wait_idle();

    write_base('1);
    random_phase(300);
    wait_idle();

    wide = {$urandom, $urandom};
    write_base(wide[FRAME_W-1:0]);
    random_phase(260);
    wait_idle();

    write_base(FRAME_W'($urandom_range(200, 1)));
    random_phase(270);
    add_req('0, FRAME_W'({$urandom, $urandom}), '1);
    wait_idle();

    repeat (64) @(posedge clk);
    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/pgfill_pkg.sv
rtl/core/pgfill_mem.sv
rtl/core/pgfill_walk.sv
rtl/core/four_level_page_table_fill.sv
rtl/core/pgfill_chk.sv
tb/tb.sv
